[rtl/sms_pkg.sv]
// sms_pkg: shared constants, payload structs and the job record for the
// subpixel minimum search block. No dependencies.
package sms_pkg;

  // cost precision and derived widths
  localparam int COST_BITS  = 32;
  localparam int OFFS_BITS  = 8;
  localparam int X_BITS     = OFFS_BITS + 1;
  localparam int FRAC_BITS  = 8;
  localparam int DIFF_BITS  = COST_BITS + 3;
  localparam int DPOS_BITS  = COST_BITS + 2;
  localparam int DEN_BITS   = COST_BITS + 3;
  localparam int NUM_BITS   = COST_BITS + FRAC_BITS + 1;
  localparam int SUM_BITS   = NUM_BITS + 1;
  localparam int CNT_BITS   = $clog2(NUM_BITS);
  localparam int POS_BITS   = 16;

  localparam logic [OFFS_BITS-1:0] MAX_ITEMS = 8'd255;
  localparam logic [7:0]           FIRST_POSITION_RESET = 8'd6;
  localparam logic [SUM_BITS-1:0]  POS_MAX = SUM_BITS'(65535);

  // job queue between tracker and solver
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_ADDR  = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [31:0] cost;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position_q8;
    logic                not_interpolated;
  } out_item_t;

  // one finished run, waiting for the sub-position solve
  typedef struct packed {
    logic [X_BITS-1:0]    x;
    logic [COST_BITS-1:0] y;
    logic [COST_BITS-1:0] ym;
    logic [COST_BITS-1:0] yp;
    logic                 edge_hit;
  } job_t;

endpackage

[rtl/sms_front.sv]
// sms_front: per-item minimum tracker. Follows the least cost, its neighbours
// and its offset, and emits one job at the end of each run. Uses sms_pkg.
module sms_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take_item,
  input  sms_pkg::in_item_t   item,
  input  logic [7:0]          first_position,
  output logic                job_push,
  output sms_pkg::job_t       job
);

  logic [sms_pkg::OFFS_BITS-1:0] item_count, item_count_next;
  logic [sms_pkg::OFFS_BITS-1:0] best_offset, best_offset_next;
  logic [sms_pkg::COST_BITS-1:0] best_cost, best_cost_next;
  logic [sms_pkg::COST_BITS-1:0] previous_cost, previous_cost_next;
  logic [sms_pkg::COST_BITS-1:0] cost_before_best, cost_before_best_next;
  logic [sms_pkg::COST_BITS-1:0] cost_after_best, cost_after_best_next;
  logic                          after_pending, after_pending_next;
  logic [sms_pkg::COST_BITS-1:0] cost_in;

  assign cost_in = item.cost[sms_pkg::COST_BITS-1:0];

  // tracker update for one cost
  always_comb begin
    item_count_next       = item_count;
    best_offset_next      = best_offset;
    best_cost_next        = best_cost;
    previous_cost_next    = previous_cost;
    cost_before_best_next = cost_before_best;
    cost_after_best_next  = cost_after_best;
    after_pending_next    = after_pending;
    if (item_count != sms_pkg::MAX_ITEMS) begin
      if (after_pending) begin
        cost_after_best_next = cost_in;
        after_pending_next   = 1'b0;
      end
      if (item_count == '0 || cost_in < best_cost ||
          (cost_in == best_cost && best_offset != '0)) begin
        cost_before_best_next = previous_cost;
        best_cost_next        = cost_in;
        best_offset_next      = item_count;
        after_pending_next    = 1'b1;
      end
      previous_cost_next = cost_in;
      item_count_next    = item_count + 1'b1;
    end
  end

  // job built from the state after the last cost
  assign job_push      = take_item && item.is_last;
  assign job.x         = {1'b0, first_position} + {1'b0, best_offset_next};
  assign job.y         = best_cost_next;
  assign job.ym        = cost_before_best_next;
  assign job.yp        = cost_after_best_next;
  assign job.edge_hit  = after_pending_next || (best_offset_next == '0);

  // run state, cleared at the end of each run
  always_ff @(posedge clk) begin
    if (rst || (take_item && item.is_last)) begin
      item_count       <= '0;
      best_offset      <= '0;
      best_cost        <= '0;
      previous_cost    <= '0;
      cost_before_best <= '0;
      cost_after_best  <= '0;
      after_pending    <= 1'b0;
    end else if (take_item) begin
      item_count       <= item_count_next;
      best_offset      <= best_offset_next;
      best_cost        <= best_cost_next;
      previous_cost    <= previous_cost_next;
      cost_before_best <= cost_before_best_next;
      cost_after_best  <= cost_after_best_next;
      after_pending    <= after_pending_next;
    end
  end

endmodule

[rtl/sms_queue.sv]
// sms_queue: short job queue that decouples the tracker from the solver.
// Uses sms_pkg for the job record and depth.
module sms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  sms_pkg::job_t wr_job,
  input  logic          rd,
  output sms_pkg::job_t rd_job,
  output logic          q_full,
  output logic          q_empty
);

  sms_pkg::job_t                  entries [sms_pkg::QUEUE_DEPTH];
  logic [sms_pkg::QUEUE_ADDR-1:0] wr_ptr;
  logic [sms_pkg::QUEUE_ADDR-1:0] rd_ptr;
  logic [sms_pkg::QUEUE_ADDR:0]   count;
  logic                           do_wr;
  logic                           do_rd;

  assign q_full  = (count == (sms_pkg::QUEUE_ADDR + 1)'(sms_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/sms_back.sv]
// sms_back: sub-position solver. Fits the parabola, divides bit-serially,
// rounds, clamps and holds the result for the output side. Uses sms_pkg.
module sms_back (
  input  logic               clk,
  input  logic               rst,
  input  sms_pkg::job_t      head,
  input  logic               job_empty,
  output logic               job_pop,
  output sms_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FINISH} state_t;

  state_t                          state;
  sms_pkg::job_t                   job;
  logic [sms_pkg::NUM_BITS-1:0]    dividend;
  logic [sms_pkg::DEN_BITS-1:0]    divisor;
  logic [sms_pkg::DEN_BITS:0]      rem;
  logic [sms_pkg::NUM_BITS-1:0]    quo;
  logic [sms_pkg::CNT_BITS-1:0]    cnt;
  logic                            neg;
  logic                            flat;
  logic                            out_valid;

  logic signed [sms_pkg::DIFF_BITS-1:0] d;
  logic signed [sms_pkg::COST_BITS:0]   num;
  logic [sms_pkg::COST_BITS:0]          num_abs;
  logic [sms_pkg::DPOS_BITS-1:0]        d_pos;
  logic                                 flat_c;
  logic [sms_pkg::DEN_BITS:0]           rem_shift;
  logic                                 q_bit;
  logic [sms_pkg::SUM_BITS-1:0]         base;
  logic [sms_pkg::SUM_BITS-1:0]         q_ext;
  logic [sms_pkg::SUM_BITS-1:0]         pos_sum;
  logic [sms_pkg::POS_BITS-1:0]         pos_clamped;
  logic                                 out_free;

  // curvature and numerator of the parabola fit
  always_comb begin
    d = $signed({{(sms_pkg::DIFF_BITS - sms_pkg::COST_BITS){1'b0}}, job.ym})
      + $signed({{(sms_pkg::DIFF_BITS - sms_pkg::COST_BITS){1'b0}}, job.yp})
      - $signed({{(sms_pkg::DIFF_BITS - sms_pkg::COST_BITS - 1){1'b0}}, job.y, 1'b0});
    num     = $signed({1'b0, job.ym}) - $signed({1'b0, job.yp});
    num_abs = num[sms_pkg::COST_BITS] ? (~num + 1'b1) : num;
    d_pos   = d[sms_pkg::DPOS_BITS-1:0];
    flat_c  = job.edge_hit || d[sms_pkg::DIFF_BITS-1] || (d == '0);
  end

  // one restoring divide step
  always_comb begin
    rem_shift = {rem[sms_pkg::DEN_BITS-1:0], dividend[sms_pkg::NUM_BITS-1]};
    q_bit     = (rem_shift >= {1'b0, divisor});
  end

  // add or subtract the rounded fraction, clamp to the Q8.8 range
  always_comb begin
    base  = sms_pkg::SUM_BITS'({job.x, {sms_pkg::FRAC_BITS{1'b0}}});
    q_ext = sms_pkg::SUM_BITS'(quo);
    if (neg) begin
      pos_sum = (q_ext > base) ? '0 : (base - q_ext);
    end else begin
      pos_sum = base + q_ext;
    end
    pos_clamped = (pos_sum > sms_pkg::POS_MAX) ? {sms_pkg::POS_BITS{1'b1}}
                                               : pos_sum[sms_pkg::POS_BITS-1:0];
  end

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in the finish cycle a popped result is replaced below
      if (pop && out_valid && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job   <= head;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          neg      <= num[sms_pkg::COST_BITS];
          flat     <= flat_c;
          dividend <= sms_pkg::NUM_BITS'({num_abs[sms_pkg::COST_BITS-1:0],
                                          {sms_pkg::FRAC_BITS{1'b0}}})
                    + sms_pkg::NUM_BITS'(d_pos);
          divisor  <= {d_pos[sms_pkg::DPOS_BITS-1:0], 1'b0};
          rem      <= '0;
          quo      <= '0;
          cnt      <= '0;
          state    <= flat_c ? S_FINISH : S_DIV;
        end
        S_DIV: begin
          rem      <= q_bit ? (rem_shift - {1'b0, divisor}) : rem_shift;
          quo      <= {quo[sms_pkg::NUM_BITS-2:0], q_bit};
          dividend <= {dividend[sms_pkg::NUM_BITS-2:0], 1'b0};
          cnt      <= cnt + 1'b1;
          if (cnt == sms_pkg::CNT_BITS'(sms_pkg::NUM_BITS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result.position_q8      <= pos_clamped;
            result.not_interpolated <= flat;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/subpixel_minimum_search.sv]
// subpixel_minimum_search: top level. Holds the first-position register and
// joins sms_front, sms_queue and sms_back. Uses sms_pkg.
//
//   channel   direction  handshake            transaction
//   item      in         push / full          one cost with its last flag
//   result    out        empty / pop          position_q8, not_interpolated
//   config    in         config_write         first_position, no read-back
//
// Costs are taken one per cycle while full is low; full rises only when
// the four-entry job queue holds four finished runs. Each run takes the
// solver through load, prepare, 41 bit-serial divide steps and finish;
// edge or flat runs skip the divide steps. Reset clears the run state and
// the queue, empties the result register and sets first_position to 6.
module subpixel_minimum_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sms_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output sms_pkg::out_item_t result,
  input  logic               config_write,
  input  logic [7:0]         config_data
);

  logic [7:0]    first_position;
  logic          take_item;
  logic          job_push;
  sms_pkg::job_t job_in;
  sms_pkg::job_t job_head;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_position <= sms_pkg::FIRST_POSITION_RESET;
    end else if (config_write) begin
      first_position <= config_data;
    end
  end

  assign full      = job_full;
  assign take_item = push && !job_full;

  sms_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take_item      (take_item),
    .item           (item),
    .first_position (first_position),
    .job_push       (job_push),
    .job            (job_in)
  );

  sms_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (job_in),
    .rd      (job_pop),
    .rd_job  (job_head),
    .q_full  (job_full),
    .q_empty (job_empty)
  );

  sms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
